>>> hdl/trn_pkg.sv
package trn_pkg;

   // Telnet command bytes
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_IAC  = 8'd255;

   // Options handled locally
   localparam logic [7:0] OPTION_ECHO = 8'd1;
   localparam logic [7:0] OPTION_SGA  = 8'd3;

   // Output destinations
   localparam logic DEST_TERMINAL = 1'b0;
   localparam logic DEST_PEER     = 1'b1;

   // Job queue depth default (power of two, at least 2)
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       destination;
      logic [7:0] out_byte;
      logic       last;
      logic       echo_active;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_DATA,
      JOB_TRIPLE,
      JOB_OPEN
   } job_kind_type;

   // One classified item, expanded into beats by the back end
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   verb;
      logic [7:0]   value;
      logic         echo_active;
   } job_type;

endpackage

>>> hdl/telnet_receive_negotiator_unit.sv
// Telnet receive negotiator.
// req channel: one beat per received byte (command = 0) or per connection
// open (command = 1). Bytes go through the IAC layer; data bytes go to the
// terminal, negotiation replies go to the peer.
// rsp channel: zero to six beats per request, in request order; last marks
// the final beat of a request, echo_active gives the agreed state after it.
// With the queue empty and the output free, the first beat of a request is
// written into the queue at the accepting edge and becomes valid once it has
// been loaded into the output register.
// Throughput: one request per cycle while the queue has room; the output
// register drains one beat per cycle unless the receiver stalls.
// A job queue of QUEUE_DEPTH entries between front and back absorbs bursts;
// req_stall is high while that queue is full.
// When the receiver stalls, the current beat holds in the output register
// and the queue fills; the front keeps accepting until it is full.
// Reset clears all negotiation state, empties the queue and drops rsp_valid.
// No awaiting-reply bit is set until an open command arrives.
module telnet_receive_negotiator_unit
   import trn_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // power of two, >= 2
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    job_push;
   job_type job;
   logic    queue_full;
   logic    job_pop;
   logic    head_valid;
   job_type head_job;

   // back-pressure to the link only when the job queue has no room
   assign req_stall = queue_full;

   // front: IAC parsing, option negotiation, one job per request at most
   trn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (job)
   );

   // decouples classification from beat expansion
   trn_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: expands each job into 1, 3 or 6 beats via the output register
   trn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hdl/trn_front.sv
module trn_front
   import trn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    job_push,
   output job_type job
);

   logic       after_iac_ff,   after_iac_in;
   logic       pending_ff,     pending_in;
   logic       in_sub_ff,      in_sub_in;
   logic [7:0] prev_byte_ff,   prev_byte_in;
   logic       echo_ff,        echo_in;
   logic       sga_ff,         sga_in;
   logic       wait_echo_ff,   wait_echo_in;
   logic       wait_sga_ff,    wait_sga_in;

   logic       accept;
   logic [7:0] c;
   logic [7:0] verb;
   logic       is_echo;
   logic       agreed_new;
   logic       awaiting_cur;
   logic       have_reply;
   logic [7:0] reply;

   assign accept = req_valid && !queue_full;
   assign c      = req_data.data_byte;
   assign verb   = prev_byte_ff;

   always_comb begin
      after_iac_in = after_iac_ff;
      pending_in   = pending_ff;
      in_sub_in    = in_sub_ff;
      prev_byte_in = prev_byte_ff;
      echo_in      = echo_ff;
      sga_in       = sga_ff;
      wait_echo_in = wait_echo_ff;
      wait_sga_in  = wait_sga_ff;
      job_push     = 1'b0;
      job.kind     = JOB_DATA;
      job.verb     = 8'd0;
      job.value    = c;
      is_echo      = (c == OPTION_ECHO);
      agreed_new   = is_echo ? echo_ff : sga_ff;
      awaiting_cur = is_echo ? wait_echo_ff : wait_sga_ff;
      have_reply   = 1'b0;
      reply        = B_DONT;

      if (accept) begin
         if (req_data.command) begin
            after_iac_in = 1'b0;
            pending_in   = 1'b0;
            in_sub_in    = 1'b0;
            prev_byte_in = 8'd0;
            echo_in      = 1'b0;
            sga_in       = 1'b0;
            wait_echo_in = 1'b1;
            wait_sga_in  = 1'b1;
            job_push     = 1'b1;
            job.kind     = JOB_OPEN;
         end else begin
            if (after_iac_ff) begin
               case (c)
                  B_SE: in_sub_in = 1'b0;
                  B_SB: in_sub_in = 1'b1;
                  B_WILL, B_WONT, B_DO, B_DONT: pending_in = 1'b1;
                  B_IAC: job_push = 1'b1;
                  default: ;
               endcase
               after_iac_in = 1'b0;
            end else if (c == B_IAC) begin
               after_iac_in = 1'b1;
            end else if (pending_ff) begin
               pending_in = 1'b0;
               if (c == OPTION_ECHO || c == OPTION_SGA) begin
                  case (verb)
                     B_DO: begin
                        agreed_new = 1'b1;
                        reply      = B_WILL;
                        have_reply = 1'b1;
                     end
                     B_DONT: begin
                        agreed_new = 1'b0;
                        reply      = B_WONT;
                        have_reply = 1'b1;
                     end
                     B_WILL, B_WONT: begin
                        reply      = B_DONT;
                        have_reply = 1'b1;
                     end
                     default: ;
                  endcase
                  // confirm only while a reply is still awaited
                  if (is_echo) begin
                     echo_in = agreed_new;
                     if (have_reply && awaiting_cur) wait_echo_in = 1'b0;
                  end else begin
                     sga_in = agreed_new;
                     if (have_reply && awaiting_cur) wait_sga_in = 1'b0;
                  end
                  if (have_reply && awaiting_cur) begin
                     job_push = 1'b1;
                     job.kind = JOB_TRIPLE;
                     job.verb = reply;
                  end
               end else if (verb inside {B_WILL, B_WONT}) begin
                  job_push = 1'b1;
                  job.kind = JOB_TRIPLE;
                  job.verb = B_DONT;
               end else if (verb inside {B_DO, B_DONT}) begin
                  job_push = 1'b1;
                  job.kind = JOB_TRIPLE;
                  job.verb = B_WONT;
               end
            end else if (!in_sub_ff) begin
               job_push = 1'b1;
            end
            prev_byte_in = c;
         end
      end
      job.echo_active = echo_in && sga_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_iac_ff <= 1'b0;
         pending_ff   <= 1'b0;
         in_sub_ff    <= 1'b0;
         prev_byte_ff <= 8'd0;
         echo_ff      <= 1'b0;
         sga_ff       <= 1'b0;
         wait_echo_ff <= 1'b0;
         wait_sga_ff  <= 1'b0;
      end else begin
         after_iac_ff <= after_iac_in;
         pending_ff   <= pending_in;
         in_sub_ff    <= in_sub_in;
         prev_byte_ff <= prev_byte_in;
         echo_ff      <= echo_in;
         sga_ff       <= sga_in;
         wait_echo_ff <= wait_echo_in;
         wait_sga_ff  <= wait_sga_in;
      end
   end

endmodule

>>> hdl/trn_queue.sv
module trn_queue
   import trn_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(QUEUE_DEPTH);

   job_type       entries_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign full       = (count_ff == DEPTH_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("job popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT) else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");
`endif

endmodule

>>> hdl/trn_back.sv
module trn_back
   import trn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    beat;
   logic       load;

   // beat of the head job at position idx_ff
   always_comb begin
      beat.destination = DEST_PEER;
      beat.out_byte    = B_IAC;
      beat.last        = 1'b0;
      beat.echo_active = head_job.echo_active;
      case (head_job.kind)
         JOB_DATA: begin
            beat.destination = DEST_TERMINAL;
            beat.out_byte    = head_job.value;
            beat.last        = 1'b1;
         end
         JOB_TRIPLE: begin
            case (idx_ff)
               3'd1:    beat.out_byte = head_job.verb;
               3'd2:    beat.out_byte = head_job.value;
               default: beat.out_byte = B_IAC;
            endcase
            beat.last = (idx_ff == 3'd2);
         end
         JOB_OPEN: begin
            case (idx_ff)
               3'd1, 3'd4: beat.out_byte = B_WILL;
               3'd2:       beat.out_byte = OPTION_ECHO;
               3'd5:       beat.out_byte = OPTION_SGA;
               default:    beat.out_byte = B_IAC;
            endcase
            beat.last = (idx_ff == 3'd5);
         end
         default: ;
      endcase
   end

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && beat.last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = beat.last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= beat;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
